// ===== rtl/shh_pkg.sv =====
// shared types, constants and round tables for the sha-1 / sha-256 hasher
// no dependencies
package shh_pkg;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [60:0] COUNT_MAX = {61{1'b1}};

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam logic MODE_SHA256 = 1'b0;
	localparam logic MODE_SHA1 = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_FINAL,
		ST_EMIT
	} shh_state_t;

	// controller to datapath
	typedef struct packed {
		logic absorb;     // write byte, bump counters
		logic start;      // load round vars, clear round counter
		logic round;      // execute one round
		logic update;     // add round vars into hash words
		logic pad_byte;   // write next pad byte at fill position
		logic len_block;  // write length field, padding block ready
		logic init;       // reload initial values
	} shh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic block_full;
		logic last_round;
		logic pad_done;   // padding reached length field or block end
		logic pad_spill;  // padding needs an extra block
	} shh_stat_t;

	function automatic logic [31:0] sha256_iv(input logic [2:0] i);
		case (i)
			3'd0: sha256_iv = 32'h6A09E667;
			3'd1: sha256_iv = 32'hBB67AE85;
			3'd2: sha256_iv = 32'h3C6EF372;
			3'd3: sha256_iv = 32'hA54FF53A;
			3'd4: sha256_iv = 32'h510E527F;
			3'd5: sha256_iv = 32'h9B05688C;
			3'd6: sha256_iv = 32'h1F83D9AB;
			default: sha256_iv = 32'h5BE0CD19;
		endcase
	endfunction

	function automatic logic [31:0] sha1_iv(input logic [2:0] i);
		case (i)
			3'd0: sha1_iv = 32'h67452301;
			3'd1: sha1_iv = 32'hEFCDAB89;
			3'd2: sha1_iv = 32'h98BADCFE;
			3'd3: sha1_iv = 32'h10325476;
			3'd4: sha1_iv = 32'hC3D2E1F0;
			default: sha1_iv = 32'h0;
		endcase
	endfunction

	function automatic logic [31:0] sha1_k(input logic [6:0] r);
		if (r < 7'd20) sha1_k = 32'h5A827999;
		else if (r < 7'd40) sha1_k = 32'h6ED9EBA1;
		else if (r < 7'd60) sha1_k = 32'h8F1BBCDC;
		else sha1_k = 32'hCA62C1D6;
	endfunction

	function automatic logic [31:0] sha256_k(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
		};
		sha256_k = k[r];
	endfunction

endpackage

// ===== rtl/shh_if.sv =====
// valid/ready channel interfaces for input items and digest words
// depends on nothing
interface shh_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] data_byte;
	modport source (output valid, operation, data_byte, input ready);
	modport sink (input valid, operation, data_byte, output ready);
endinterface

interface shh_out_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last;
	logic length_error;
	modport source (output valid, digest_word, word_index, last, length_error, input ready);
	modport sink (input valid, digest_word, word_index, last, length_error, output ready);
endinterface

// ===== rtl/shh_ctrl.sv =====
// controller state machine: sequences absorb, rounds, padding and emission
// depends on shh_pkg
module shh_ctrl
	import shh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_op,
	output logic       in_ready,
	input  logic       out_fire,
	input  logic       out_last,
	input  shh_stat_t  stat,
	output shh_cmd_t   cmd,
	output logic       emit
);
	shh_state_t state_q, state_d;
	logic final_q, final_d;   // current compression is the length block

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

	always_comb begin
		state_d = state_q;
		final_d = final_q;
		cmd = '0;
		in_ready = 1'b0;
		emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_ABSORB) begin
						cmd.absorb = 1'b1;
						if (stat.block_full) begin
							final_d = 1'b0;
							state_d = ST_ROUND;
							cmd.start = 1'b1;
						end
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.last_round) state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.update = 1'b1;
				state_d = final_q ? ST_EMIT : (stat.pad_spill ? ST_PAD : ST_IDLE);
			end
			ST_PAD: begin
				cmd.pad_byte = 1'b1;
				if (stat.pad_done) begin
					cmd.start = 1'b1;
					state_d = ST_ROUND;
					final_d = !stat.pad_spill;
					cmd.len_block = !stat.pad_spill;
				end
			end
			ST_EMIT: begin
				emit = 1'b1;
				if (out_fire && out_last) begin
					cmd.init = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/shh_dp.sv =====
// datapath: byte counter, message block in the schedule window, round unit and hash words
// depends on shh_pkg
module shh_dp
	import shh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mode,
	input  logic        cfg_we,
	input  logic        cfg_mode,
	input  logic [7:0]  data_byte,
	input  shh_cmd_t    cmd,
	input  logic [2:0]  out_idx,
	output shh_stat_t   stat,
	output logic [31:0] hash_word,
	output logic        ovf
);
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic        ovf_q;
	logic        spill_q;   // padding byte written, extra block pending
	logic        padded_q;  // pad marker already placed
	logic [31:0] h_q [8];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [6:0]  rnd_q;

	logic [31:0] wnew, w_cur, t1, t2, s1t, f, kk, w1;
	logic [63:0] bits;
	logic        init_mode;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	assign bits = {count_q, 3'b000};
	assign init_mode = cfg_we ? cfg_mode : mode;
	assign stat.block_full = (fill_q == 6'd63);
	assign stat.last_round = (mode == MODE_SHA1) ? (rnd_q == 7'd79) : (rnd_q == 7'd63);
	// pad until the length field, or until block end while a spill is pending
	assign stat.pad_done = padded_q && (spill_q ? (fill_q == 6'd0) : (fill_q == 6'd56));
	assign stat.pad_spill = spill_q;
	assign hash_word = h_q[out_idx];
	assign ovf = ovf_q;

	// message schedule
	always_comb begin
		w1 = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		if (mode == MODE_SHA1) begin
			wnew = {w1[30:0], w1[31]};
		end else begin
			wnew = w_q[0]
				+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
				+ w_q[9]
				+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
		end
		w_cur = (rnd_q < 7'd16) ? w_q[0] : wnew;
	end

	// round function
	always_comb begin
		kk = (mode == MODE_SHA1) ? sha1_k(rnd_q) : sha256_k(rnd_q[5:0]);
		if (rnd_q < 7'd20 || rnd_q >= 7'd40 && rnd_q < 7'd60) begin
			f = (rnd_q < 7'd20) ? ((v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]))
				: ((v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]));
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
		end
		s1t = rotr(v_q[0], 27) + f + v_q[4] + kk + w_cur;
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kk + w_cur;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			spill_q <= 1'b0;
			padded_q <= 1'b0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_iv(3'(i));
		end else if (cfg_we || cmd.init) begin
			fill_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			spill_q <= 1'b0;
			padded_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= (init_mode == MODE_SHA1) ? sha1_iv(3'(i)) : sha256_iv(3'(i));
		end else begin
			if (cmd.absorb) begin
				fill_q <= fill_q + 6'd1;
				if (count_q == COUNT_MAX) ovf_q <= 1'b1;
				else count_q <= count_q + 61'd1;
			end
			if (cmd.pad_byte && !stat.pad_done) begin
				fill_q <= fill_q + 6'd1;
				padded_q <= 1'b1;
				if (!padded_q && fill_q > 6'd55) spill_q <= 1'b1;
			end
			// spill block hashed, the length block follows
			if (cmd.update) spill_q <= 1'b0;
			if (cmd.start) rnd_q <= '0;
			if (cmd.round) rnd_q <= rnd_q + 7'd1;
			if (cmd.update)
				for (int i = 0; i < 8; i++)
					if (mode == MODE_SHA256 || i < 5) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	// schedule window doubles as the block buffer while no rounds run
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
			if (mode == MODE_SHA1) begin
				v_q[0] <= s1t;
				v_q[1] <= v_q[0];
				v_q[2] <= rotr(v_q[1], 2);
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3];
			end else begin
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
			end
		end else begin
			// big-endian byte lane within each word
			if (cmd.absorb)
				w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte;
			if (cmd.pad_byte && !stat.pad_done)
				w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <=
					padded_q ? 8'h00 : PAD_BYTE;
			if (cmd.len_block) begin
				w_q[14] <= bits[63:32];
				w_q[15] <= bits[31:0];
			end
			if (cmd.start)
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end
endmodule

// ===== rtl/sha1_sha256_hasher_core.sv =====
// channel     dir  payload                                      handshake
// in_ch       in   operation, data_byte                         valid/ready
// out_ch      out  digest_word, word_index, last, length_error  valid/ready
// cfg         in   hash_mode (cfg_data[0])                      cfg_we, no wait
//
// absorb: bytes are taken while idle; a full block then adds 64 (sha-256) or 80 (sha-1)
//   rounds plus an update, run on the single shared round unit
// finish: padding bytes one per cycle up to the length field, one or two
//   compressions, then one digest word per cycle while out_ch.ready is high
// reset clears control state and loads the sha-256 initial values
// input is held off (ready low) during rounds, padding and digest output
// depends on shh_pkg, shh_if, shh_ctrl, shh_dp
module sha1_sha256_hasher_core
	import shh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_data,
	shh_in_if.sink    in_ch,
	shh_out_if.source out_ch
);
	shh_cmd_t   cmd;
	shh_stat_t  stat;
	logic       mode_q;
	logic [2:0] idx_q;
	logic       emit, out_fire, out_last;
	logic [31:0] hash_word;
	logic       ovf;

	// mode register, hash words reload inside the datapath on the same write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_SHA256;
		else if (cfg_we) mode_q <= cfg_data;
	end

	// digest word counter
	assign out_last = (mode_q == MODE_SHA1) ? (idx_q == 3'd4) : (idx_q == 3'd7);
	assign out_fire = out_ch.valid && out_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (out_fire) idx_q <= out_last ? 3'd0 : idx_q + 3'd1;
	end

	shh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (in_ch.ready),
		.out_fire (out_fire),
		.out_last (out_last),
		.stat     (stat),
		.cmd      (cmd),
		.emit     (emit)
	);

	shh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.cfg_we    (cfg_we),
		.cfg_mode  (cfg_data),
		.data_byte (in_ch.data_byte),
		.cmd       (cmd),
		.out_idx   (idx_q),
		.stat      (stat),
		.hash_word (hash_word),
		.ovf       (ovf)
	);

	// hash words are registers and hold steady while emitting
	assign out_ch.valid = emit;
	assign out_ch.digest_word = hash_word;
	assign out_ch.word_index = idx_q;
	assign out_ch.last = out_last;
	assign out_ch.length_error = ovf;
endmodule

// ===== rtl/shh_checker.sv =====
// port-level checker for the hasher core, bound to the top level
// depends on sha1_sha256_hasher_core through the bind
module shh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_index,
	input logic       last
);
	// no input taken while a digest is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready during digest");
	// last word ends the digest
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid) else $error("valid after last");
	// index advances by one after a non-last word
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && word_index == $past(word_index) + 3'd1)
		else $error("word index skip");
	// stalled word keeps its index
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_index)) else $error("stall");
endmodule

bind sha1_sha256_hasher_core shh_checker u_shh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.word_index (out_ch.word_index),
	.last       (out_ch.last)
);
